// ===== rtl/tlpt_pkg.sv =====
// shared types, sizes and codes for the two-level page table core
package tlpt_pkg;

    // pool of second-level tables and address split
    localparam int TABLE_SLOTS = 64;
    localparam int DIR_ENTRIES = 1024;
    localparam int IDX_W       = 10;
    localparam int OFFS_W      = 12;
    localparam int DIR_LSB     = 22;
    localparam int TBL_LSB     = 12;
    localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
    localparam int TADDR_W     = SLOT_W + IDX_W;
    localparam int TBL_DEPTH   = TABLE_SLOTS * DIR_ENTRIES;
    localparam int PAGE_W      = $clog2(TBL_DEPTH + 1);

    // field widths seen at the ports
    localparam int LIMIT_W     = 7;
    localparam int TUSED_W     = 7;
    localparam int PCOUNT_W    = 17;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    // queue between front and back
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    // operation codes
    typedef enum logic [1:0] {
        OP_MAP   = 2'd0,
        OP_UNMAP = 2'd1,
        OP_XLATE = 2'd2
    } op_t;

    // front state
    typedef enum logic {
        FE_IDLE,
        FE_LOOKUP
    } fe_state_t;

    // back state
    typedef enum logic {
        BE_IDLE,
        BE_UPDATE
    } be_state_t;

    // clearing pass state
    typedef enum logic {
        CLR_RUN,
        CLR_DONE
    } clr_state_t;

    // clearing pass status shared with both memories
    typedef struct packed {
        logic               active;
        logic [TADDR_W-1:0] idx;
    } clr_t;

    // classified request travelling from front to back
    typedef struct packed {
        logic [1:0]         op;
        logic               hit;
        logic [TADDR_W-1:0] taddr;
        logic [31:0]        new_pte;
        logic [OFFS_W-1:0]  offs;
        logic [CNT_W-1:0]   tables_used;
    } q_entry_t;

    // queue fill status
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // result handed to the output side
    typedef struct packed {
        logic                ok;
        logic [31:0]         result_addr;
        logic [PCOUNT_W-1:0] page_count;
        logic [TUSED_W-1:0]  tables_used;
    } res_t;

endpackage

// ===== rtl/tlpt_front.sv =====
// front: accepts requests, looks up the directory and allocates tables
module tlpt_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tlpt_pkg::clr_t                clr,
    input  logic                          cfg_we,
    input  logic [tlpt_pkg::LIMIT_W-1:0]  cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    in_op,
    input  logic [31:0]                   in_va,
    input  logic [31:0]                   in_pa,
    input  logic [tlpt_pkg::OFFS_W-1:0]   in_flags,
    input  tlpt_pkg::q_status_t           q_stat,
    output logic                          push,
    output tlpt_pkg::q_entry_t            push_data
);

    tlpt_pkg::fe_state_t state_reg, state_next;

    logic [tlpt_pkg::LIMIT_W-1:0]  limit_reg;
    logic [tlpt_pkg::CNT_W-1:0]    tcnt_reg, tcnt_next;
    logic [1:0]                    op_reg;
    logic [31:0]                   va_reg;
    logic [31:0]                   pa_reg;
    logic [tlpt_pkg::OFFS_W-1:0]   flags_reg;

    // directory: present bit above the slot number
    logic [tlpt_pkg::SLOT_W:0]     dir_mem [tlpt_pkg::DIR_ENTRIES];
    logic [tlpt_pkg::SLOT_W:0]     dir_rdata_reg;

    logic                          accept;
    logic                          present;
    logic                          pool_full;
    logic                          alloc;
    logic                          alloc_we;
    logic [tlpt_pkg::SLOT_W-1:0]   slot;
    logic [tlpt_pkg::IDX_W-1:0]    di;
    logic [tlpt_pkg::IDX_W-1:0]    ti;
    logic [31:0]                   cap32;
    logic [tlpt_pkg::CNT_W-1:0]    tcnt_after;

    assign accept = in_valid && in_ready;
    assign di     = va_reg[31:tlpt_pkg::DIR_LSB];
    assign ti     = va_reg[tlpt_pkg::DIR_LSB-1:tlpt_pkg::TBL_LSB];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tlpt_pkg::FE_IDLE:
            begin
                if (accept)
                    state_next = tlpt_pkg::FE_LOOKUP;
            end
            tlpt_pkg::FE_LOOKUP:
            begin
                if (!q_stat.full)
                    state_next = tlpt_pkg::FE_IDLE;
            end
            default: state_next = tlpt_pkg::FE_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready = 1'b0;
        push     = 1'b0;
        case (state_reg)
            tlpt_pkg::FE_IDLE:   in_ready = !clr.active;
            tlpt_pkg::FE_LOOKUP: push     = !q_stat.full;
            default:
            begin
                in_ready = 1'b0;
                push     = 1'b0;
            end
        endcase
    end

    // classify: existing table, new allocation or miss
    always_comb
    begin
        present    = dir_rdata_reg[tlpt_pkg::SLOT_W];
        cap32      = (32'(limit_reg) < 32'(tlpt_pkg::TABLE_SLOTS)) ?
                     32'(limit_reg) : 32'(tlpt_pkg::TABLE_SLOTS);
        pool_full  = (32'(tcnt_reg) >= cap32);
        alloc      = (op_reg == tlpt_pkg::OP_MAP) && !present && !pool_full;
        slot       = present ? dir_rdata_reg[tlpt_pkg::SLOT_W-1:0]
                             : tcnt_reg[tlpt_pkg::SLOT_W-1:0];
        tcnt_after = alloc ? tcnt_reg + 1'b1 : tcnt_reg;
        alloc_we   = alloc && push;
        tcnt_next  = push ? tcnt_after : tcnt_reg;

        push_data.op          = op_reg;
        push_data.hit         = present || alloc;
        push_data.taddr       = {slot, ti};
        push_data.new_pte     = {pa_reg[31:tlpt_pkg::TBL_LSB],
                                 flags_reg[tlpt_pkg::OFFS_W-1:1], 1'b1};
        push_data.offs        = va_reg[tlpt_pkg::OFFS_W-1:0];
        push_data.tables_used = tcnt_after;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tlpt_pkg::FE_IDLE;
            limit_reg <= tlpt_pkg::LIMIT_RESET;
            tcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tcnt_reg  <= tcnt_next;
            if (cfg_we)
                limit_reg <= cfg_wdata;
        end
    end

    // request hold registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= in_op;
            va_reg    <= in_va;
            pa_reg    <= in_pa;
            flags_reg <= in_flags;
        end
    end

    // directory memory: cleared after reset, written on allocation
    always_ff @(posedge clk)
    begin
        if (clr.active)
            dir_mem[clr.idx[tlpt_pkg::IDX_W-1:0]] <= '0;
        else if (alloc_we)
            dir_mem[di] <= {1'b1, slot};
        if (accept)
            dir_rdata_reg <= dir_mem[in_va[31:tlpt_pkg::DIR_LSB]];
    end

    // allocation never runs past the pool
    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(tcnt_reg) <= 32'(tlpt_pkg::TABLE_SLOTS))
        else $error("table count beyond pool size");

    // a table is only allocated for a map that found an empty slot
    a_alloc_map: assert property (@(posedge clk) disable iff (!rst_n)
        (tcnt_reg != $past(tcnt_reg)) |-> ($past(alloc_we) && $past(!present)))
        else $error("table count changed without an allocation");

endmodule

// ===== rtl/tlpt_queue.sv =====
// short queue of classified requests between front and back
module tlpt_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tlpt_pkg::q_entry_t   push_data,
    input  logic                 pop,
    output tlpt_pkg::q_entry_t   head,
    output tlpt_pkg::q_status_t  stat
);

    tlpt_pkg::q_entry_t             entries_reg [tlpt_pkg::QDEPTH];
    logic [tlpt_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [tlpt_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [tlpt_pkg::QPTR_W:0]      count_reg, count_next;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (32'(count_reg) == 32'(tlpt_pkg::QDEPTH));
    assign head       = entries_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (32'(wr_ptr_reg) == 32'(tlpt_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (32'(rd_ptr_reg) == 32'(tlpt_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && stat.full))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && stat.empty))
        else $error("pop from an empty queue");

endmodule

// ===== rtl/tlpt_back.sv =====
// back: read-modify-write of the table entry and the result register
module tlpt_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tlpt_pkg::clr_t       clr,
    input  tlpt_pkg::q_entry_t   head,
    input  tlpt_pkg::q_status_t  q_stat,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tlpt_pkg::res_t       out_res
);

    tlpt_pkg::be_state_t state_reg, state_next;

    tlpt_pkg::q_entry_t            cur_reg;
    logic [31:0]                   tbl_mem [tlpt_pkg::TBL_DEPTH];
    logic [31:0]                   tbl_rdata_reg;
    logic [tlpt_pkg::PAGE_W-1:0]   pcnt_reg, pcnt_next;
    logic                          out_valid_reg, out_valid_next;
    tlpt_pkg::res_t                res_reg;

    logic                          out_free;
    logic                          fire;
    logic                          e_present;
    logic                          tbl_we;
    logic [31:0]                   tbl_wdata;
    logic                          ok;
    logic [31:0]                   res_addr;
    logic [31:0]                   p32;
    logic [31:0]                   tu32;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tlpt_pkg::BE_IDLE:
            begin
                if (!q_stat.empty)
                    state_next = tlpt_pkg::BE_UPDATE;
            end
            tlpt_pkg::BE_UPDATE:
            begin
                if (out_free)
                    state_next = tlpt_pkg::BE_IDLE;
            end
            default: state_next = tlpt_pkg::BE_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        pop  = 1'b0;
        fire = 1'b0;
        case (state_reg)
            tlpt_pkg::BE_IDLE:   pop  = !q_stat.empty;
            tlpt_pkg::BE_UPDATE: fire = out_free;
            default:
            begin
                pop  = 1'b0;
                fire = 1'b0;
            end
        endcase
    end

    // entry update, page count and result
    always_comb
    begin
        e_present = tbl_rdata_reg[0];
        tbl_we    = 1'b0;
        tbl_wdata = '0;
        ok        = 1'b0;
        res_addr  = '0;
        pcnt_next = pcnt_reg;
        case (cur_reg.op)
            tlpt_pkg::OP_MAP:
            begin
                if (cur_reg.hit)
                begin
                    tbl_we    = 1'b1;
                    tbl_wdata = cur_reg.new_pte;
                    ok        = 1'b1;
                    if (!e_present)
                        pcnt_next = pcnt_reg + 1'b1;
                end
            end
            tlpt_pkg::OP_UNMAP:
            begin
                if (cur_reg.hit && e_present)
                begin
                    tbl_we = 1'b1;
                    ok     = 1'b1;
                    if (pcnt_reg != '0)
                        pcnt_next = pcnt_reg - 1'b1;
                end
            end
            tlpt_pkg::OP_XLATE:
            begin
                if (cur_reg.hit && e_present)
                begin
                    ok       = 1'b1;
                    res_addr = {tbl_rdata_reg[31:tlpt_pkg::TBL_LSB], cur_reg.offs};
                end
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
        p32  = 32'(pcnt_next);
        tu32 = 32'(cur_reg.tables_used);
    end

    // output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tlpt_pkg::BE_IDLE;
            pcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (fire)
                pcnt_reg <= pcnt_next;
        end
    end

    // current request and result payload
    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head;
        if (fire)
        begin
            res_reg.ok          <= ok;
            res_reg.result_addr <= res_addr;
            res_reg.page_count  <= p32[tlpt_pkg::PCOUNT_W-1:0];
            res_reg.tables_used <= tu32[tlpt_pkg::TUSED_W-1:0];
        end
    end

    // table memory: cleared after reset, one read and one write port
    always_ff @(posedge clk)
    begin
        if (clr.active)
            tbl_mem[clr.idx] <= '0;
        else if (fire && tbl_we)
            tbl_mem[cur_reg.taddr] <= tbl_wdata;
        if (pop)
            tbl_rdata_reg <= tbl_mem[head.taddr];
    end

    a_page_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pcnt_reg) <= 32'(tlpt_pkg::TBL_DEPTH))
        else $error("page count beyond table capacity");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == tlpt_pkg::BE_UPDATE))
        else $error("result raised without an entry update");

endmodule

// ===== rtl/two_level_page_table_core.sv =====
// top level of the two-level page table core: clearing pass and port packing
//
// Keeps a 32-bit two-level page table with a pool of TABLE_SLOTS (64)
// second-level tables. Each request maps, unmaps or translates one address
// and gives exactly one result. After reset the core sweeps its table
// memory once, one entry a cycle, for 65536 entries (TABLE_SLOTS * 1024);
// s_tready stays low until the sweep is done, while table_limit writes are
// taken at any time. The front reads the directory into a register as it
// takes a request, then classifies and allocates in its lookup state; the
// back reads the table entry as it pops the queue, then writes it back with
// the result in its update state. Each side reads and then writes its own
// synchronous memory, so neither side takes a new request before it is
// through with the last one. A two-entry queue between the sides and the
// result register let either side stall without holding the other.
// table_limit is meant to be written only while no request is in flight.
module two_level_page_table_core (
    input  logic        clk,
    input  logic        rst_n,
    // request: virt_addr [31:0], phys_addr [63:32], page_flags [75:64]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,
    // request: opcode [1:0]
    input  logic [1:0]  s_tuser,
    // result: result_addr [31:0], page_count [48:32], tables_used [55:49]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,
    // result: ok [0]
    output logic [0:0]  m_tuser,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata
);

    tlpt_pkg::clr_state_t  clr_state_reg, clr_state_next;
    logic [tlpt_pkg::TADDR_W-1:0] clr_idx_reg, clr_idx_next;
    tlpt_pkg::clr_t        clr;

    tlpt_pkg::q_entry_t    push_data;
    tlpt_pkg::q_entry_t    head;
    tlpt_pkg::q_status_t   q_stat;
    tlpt_pkg::res_t        res;
    logic                  push;
    logic                  pop;
    logic                  last_idx;

    assign last_idx = (clr_idx_reg == tlpt_pkg::TADDR_W'(tlpt_pkg::TBL_DEPTH - 1));

    // clearing pass next state
    always_comb
    begin
        clr_state_next = clr_state_reg;
        case (clr_state_reg)
            tlpt_pkg::CLR_RUN:
            begin
                if (last_idx)
                    clr_state_next = tlpt_pkg::CLR_DONE;
            end
            tlpt_pkg::CLR_DONE: clr_state_next = tlpt_pkg::CLR_DONE;
            default:            clr_state_next = tlpt_pkg::CLR_DONE;
        endcase
    end

    // clearing pass outputs
    always_comb
    begin
        clr.active   = 1'b0;
        clr.idx      = clr_idx_reg;
        clr_idx_next = clr_idx_reg;
        case (clr_state_reg)
            tlpt_pkg::CLR_RUN:
            begin
                clr.active   = 1'b1;
                clr_idx_next = clr_idx_reg + 1'b1;
            end
            default:
            begin
                clr.active = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_state_reg <= tlpt_pkg::CLR_RUN;
            clr_idx_reg   <= '0;
        end
        else
        begin
            clr_state_reg <= clr_state_next;
            clr_idx_reg   <= clr_idx_next;
        end
    end

    // front: directory lookup and table allocation
    tlpt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .clr       (clr),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_va     (s_tdata[31:0]),
        .in_pa     (s_tdata[63:32]),
        .in_flags  (s_tdata[75:64]),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    // queue between the two sides
    tlpt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    // back: table entry update and result
    tlpt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .clr       (clr),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    // result packing
    assign m_tdata = {res.tables_used, res.page_count, res.result_addr};
    assign m_tuser = res.ok;

    a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr.active |-> !(s_tvalid && s_tready))
        else $error("request taken during clearing pass");

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for the two-level page table core
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // unused operation code, not part of the package enum
    localparam logic [1:0] OP_SPARE    = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         PHASE_ITEMS = 207;

    // one request as the sender sees it
    typedef struct {
        logic [1:0]  op;
        logic [31:0] va;
        logic [31:0] pa;
        logic [11:0] flags;
    } page_req_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = tlpt_pkg::OP_MAP;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [55:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_we    = 1'b0;
    logic [6:0]  cfg_wdata = '0;

    // pending requests and the results they are due to give
    page_req_t        request_q[$];
    tlpt_pkg::res_t   result_due_q[$];
    logic [31:0]      known_va_q[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int cycles         = 0;

    // shadow copy of the page table state
    logic                        shadow_dir_valid [tlpt_pkg::DIR_ENTRIES];
    logic [tlpt_pkg::SLOT_W-1:0] shadow_dir_slot  [tlpt_pkg::DIR_ENTRIES];
    logic [31:0]                 shadow_pte       [int];
    int                          shadow_limit  = 64;
    int                          shadow_tables = 0;
    int                          shadow_pages  = 0;

    two_level_page_table_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // clock, 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // walk the shadow table, apply the operation and work out the result
    function automatic tlpt_pkg::res_t walk_and_update(logic [1:0] op, logic [31:0] va,
                                                       logic [31:0] pa, logic [11:0] fl);
        logic [9:0]      di;
        logic [9:0]      ti;
        int              pool_cap;
        int              key;
        logic            have_table;
        logic [31:0]     pte;
        tlpt_pkg::res_t  r;
        di = va[31:22];
        ti = va[21:12];
        r = '0;
        key = 0;
        pte = '0;
        pool_cap = (shadow_limit < tlpt_pkg::TABLE_SLOTS) ? shadow_limit
                                                          : tlpt_pkg::TABLE_SLOTS;
        have_table = shadow_dir_valid[di];
        // a map into an empty directory slot takes the next table if the pool allows
        if (op == tlpt_pkg::OP_MAP && !have_table && shadow_tables < pool_cap)
        begin
            shadow_dir_slot[di]  = shadow_tables[tlpt_pkg::SLOT_W-1:0];
            shadow_dir_valid[di] = 1'b1;
            shadow_tables++;
            have_table = 1'b1;
        end
        if (have_table)
        begin
            key = int'({shadow_dir_slot[di], ti});
            if (shadow_pte.exists(key))
                pte = shadow_pte[key];
        end
        case (op)
            tlpt_pkg::OP_MAP:
                if (have_table)
                begin
                    if (!pte[0])
                        shadow_pages++;
                    shadow_pte[key] = {pa[31:12], fl | 12'h001};
                    r.ok = 1'b1;
                end
            tlpt_pkg::OP_UNMAP:
                if (have_table && pte[0])
                begin
                    shadow_pte[key] = '0;
                    if (shadow_pages > 0)
                        shadow_pages--;
                    r.ok = 1'b1;
                end
            tlpt_pkg::OP_XLATE:
                if (have_table && pte[0])
                begin
                    r.result_addr = {pte[31:12], va[11:0]};
                    r.ok = 1'b1;
                end
            default:
                r.ok = 1'b0;
        endcase
        r.page_count  = shadow_pages[tlpt_pkg::PCOUNT_W-1:0];
        r.tables_used = shadow_tables[tlpt_pkg::TUSED_W-1:0];
        return r;
    endfunction

    // random request: mostly map, translate and unmap around addresses already used
    function automatic page_req_t fresh_request();
        page_req_t   q;
        int          pick;
        logic [31:0] base;
        pick = $urandom_range(99);
        q.pa = $urandom;
        q.flags = 12'($urandom_range(4095));
        q.va = $urandom;
        if (pick < 8)
        begin
            // noise: any operation code on any address
            q.op = 2'($urandom_range(3));
            return q;
        end
        pick = $urandom_range(99);
        if (pick < 40)
            q.op = tlpt_pkg::OP_MAP;
        else if (pick < 75)
            q.op = tlpt_pkg::OP_XLATE;
        else
            q.op = tlpt_pkg::OP_UNMAP;
        if (known_va_q.size() > 0 && $urandom_range(4) != 0)
        begin
            base = known_va_q[$urandom_range(known_va_q.size() - 1)];
            q.va[31:12] = base[31:12];
            // sometimes a neighbouring entry in the same table
            if ($urandom_range(5) == 0)
                q.va[21:12] = 10'($urandom_range(1023));
        end
        if (q.op == tlpt_pkg::OP_MAP)
        begin
            known_va_q.push_back(q.va);
            if (known_va_q.size() > 48)
                void'(known_va_q.pop_front());
        end
        return q;
    endfunction

    task automatic queue_req(logic [1:0] op, logic [31:0] va, logic [31:0] pa,
                             logic [11:0] fl);
        page_req_t q;
        q.op = op;
        q.va = va;
        q.pa = pa;
        q.flags = fl;
        request_q.push_back(q);
    endtask

    // hold off until every request has gone and every result has come back
    task automatic wait_drained();
        while (request_q.size() != 0 || s_tvalid || result_due_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_limit(int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value[6:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        shadow_limit = value;
    endtask

    task automatic run_phase(int limit, int send_pct, int recv_pct);
        wait_drained();
        write_limit(limit);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < PHASE_ITEMS; i++)
            request_q.push_back(fresh_request());
    endtask

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("cycle %0d: %s got %0h want %0h", cycles, what, got, want);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        page_req_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= tlpt_pkg::OP_MAP;
        end
        else
        begin
            if (s_tvalid && s_tready)
                result_due_q.push_back(walk_and_update(s_tuser, s_tdata[31:0],
                                                       s_tdata[63:32], s_tdata[75:64]));
            if (!s_tvalid || s_tready)
            begin
                if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = request_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0, nxt.flags, nxt.pa, nxt.va};
                    s_tuser  <= nxt.op;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result monitor
    always @(posedge clk)
    begin : check_results
        tlpt_pkg::res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (result_due_q.size() == 0)
            begin
                flag_mismatch("unexpected result, addr", m_tdata[31:0], 32'h0);
            end
            else
            begin
                want = result_due_q.pop_front();
                if (m_tuser[0] !== want.ok)
                    flag_mismatch("ok", 32'(m_tuser[0]), 32'(want.ok));
                if (m_tdata[31:0] !== want.result_addr)
                    flag_mismatch("result_addr", m_tdata[31:0], want.result_addr);
                if (m_tdata[48:32] !== want.page_count)
                    flag_mismatch("page_count", 32'(m_tdata[48:32]),
                                  32'(want.page_count));
                if (m_tdata[55:49] !== want.tables_used)
                    flag_mismatch("tables_used", 32'(m_tdata[55:49]),
                                  32'(want.tables_used));
            end
        end
    end

    // run limit, allowing for the clearing pass after reset
    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // stimulus sequence
    initial
    begin
        for (int i = 0; i < tlpt_pkg::DIR_ENTRIES; i++)
        begin
            shadow_dir_valid[i] = 1'b0;
            shadow_dir_slot[i]  = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // empty pool: nothing can be allocated
        write_limit(0);
        queue_req(tlpt_pkg::OP_MAP,   32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF);
        queue_req(tlpt_pkg::OP_XLATE, 32'h0000_0000, 32'h0,         12'h0);
        queue_req(tlpt_pkg::OP_UNMAP, 32'hFFFF_FFFF, 32'h0,         12'h0);
        queue_req(OP_SPARE,           32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
        wait_drained();

        // two tables: extremes, remap, unmap twice, pool used up
        write_limit(2);
        queue_req(tlpt_pkg::OP_MAP,   32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF);
        queue_req(tlpt_pkg::OP_XLATE, 32'h0000_0FFF, 32'h0,         12'h0);
        queue_req(tlpt_pkg::OP_MAP,   32'hFFFF_FFFF, 32'h0000_0000, 12'h000);
        queue_req(tlpt_pkg::OP_XLATE, 32'hFFFF_FFFF, 32'h0,         12'h0);
        queue_req(tlpt_pkg::OP_MAP,   32'h0000_1000, 32'h1234_5678, 12'h0A5);
        queue_req(tlpt_pkg::OP_MAP,   32'h0000_1000, 32'hABCD_E000, 12'h5A0);
        queue_req(tlpt_pkg::OP_XLATE, 32'h0000_1234, 32'h0,         12'h0);
        queue_req(tlpt_pkg::OP_UNMAP, 32'h0000_1000, 32'h0,         12'h0);
        queue_req(tlpt_pkg::OP_UNMAP, 32'h0000_1000, 32'h0,         12'h0);
        queue_req(tlpt_pkg::OP_XLATE, 32'h0000_1000, 32'h0,         12'h0);
        queue_req(tlpt_pkg::OP_MAP,   32'h0040_0000, 32'h5555_5000, 12'h555);
        queue_req(tlpt_pkg::OP_XLATE, 32'h0040_0000, 32'h0,         12'h0);
        queue_req(OP_SPARE,           32'h0000_0000, 32'h0,         12'h0);
        queue_req(tlpt_pkg::OP_MAP,   32'hFFC0_0000, 32'hAAAA_A000, 12'hAAA);
        queue_req(tlpt_pkg::OP_UNMAP, 32'h003F_F000, 32'h0,         12'h0);
        queue_req(tlpt_pkg::OP_MAP,   32'h003F_F000, 32'h8000_1000, 12'h800);
        queue_req(tlpt_pkg::OP_XLATE, 32'h003F_FABC, 32'h0,         12'h0);

        // random phases over limits and idling patterns
        run_phase(127, 0,  0);
        run_phase(20,  51, 0);
        run_phase(64,  0,  51);
        run_phase(45,  18, 18);
        wait_drained();
        repeat (20) @(posedge clk);

        if (result_due_q.size() != 0)
            flag_mismatch("results never arrived", 32'(result_due_q.size()), 32'h0);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
